// ===== hdl/ate_pkg.sv =====
// Shared types and constants for the ANSI text console engine.
// No dependencies; every other file imports this package.
package ate_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int MAX_PARAMS  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int OFF_W = 11;
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int PW    = 14;
    localparam int PCW   = $clog2(MAX_PARAMS + 1);
    localparam int PIW   = $clog2(MAX_PARAMS);

    localparam logic [PW-1:0] PARAM_LIMIT   = PW'(9999);
    localparam logic [7:0]    ATTR_RESET    = 8'h07;
    localparam logic [15:0]   BLANK_RESET   = 16'h0720;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RIS    = 8'h63;
    localparam logic [7:0] FIN_LO    = 8'h40;
    localparam logic [7:0] FIN_HI    = 8'h7E;

    localparam logic [7:0] FIN_CUU = 8'h41;
    localparam logic [7:0] FIN_CUD = 8'h42;
    localparam logic [7:0] FIN_CUF = 8'h43;
    localparam logic [7:0] FIN_CUB = 8'h44;
    localparam logic [7:0] FIN_CUP = 8'h48;
    localparam logic [7:0] FIN_ED  = 8'h4A;
    localparam logic [7:0] FIN_EL  = 8'h4B;
    localparam logic [7:0] FIN_HVP = 8'h66;
    localparam logic [7:0] FIN_SGR = 8'h6D;
    localparam logic [7:0] FIN_SCP = 8'h73;
    localparam logic [7:0] FIN_RCP = 8'h75;

    typedef enum logic [2:0] {
        KIND_BYTE, KIND_OPEN, KIND_CLOSE, KIND_READ, KIND_ATTR
    } t_kind;

    typedef enum logic [3:0] {
        OP_NOP, OP_SYNC, OP_PRINT, OP_LF, OP_CR, OP_TAB, OP_BS,
        OP_CSI, OP_RIS, OP_OPEN, OP_CLOSE, OP_READ, OP_ATTR
    } t_op;

    typedef enum logic [1:0] {PS_GROUND, PS_ESC, PS_CSI} t_pstate;

    typedef enum logic [2:0] {
        BS_CLEAR, BS_IDLE, BS_FILL, BS_SCROLL, BS_SGR, BS_FIN
    } t_bstate;

    typedef struct packed {
        t_op                            op;
        logic [7:0]                     ch;
        logic [OFF_W-1:0]               addr;
        logic [7:0]                     attr;
        logic [MAX_PARAMS-1:0][PW-1:0]  params;
        logic [PCW-1:0]                 pcount;
        logic                           priv;
    } t_cmd;

endpackage

// ===== hdl/ate_front.sv =====
// Front end: escape sequence parser that turns each transaction into a command.
// Depends on ate_pkg.
module ate_front import ate_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_kind,
    input  logic [7:0]       i_char_byte,
    input  logic [OFF_W-1:0] i_cell_address,
    input  logic [7:0]       i_attr_value,
    output t_cmd             o_cmd
);

    t_pstate                        r_pstate, n_pstate;
    logic [MAX_PARAMS-1:0][PW-1:0]  r_params, n_params;
    logic [PCW-1:0]                 r_pcount, n_pcount;
    logic                           r_hasd, n_hasd;
    logic                           r_priv, n_priv;

    always_comb begin
        logic [PCW-1:0] cnt;
        logic [PIW-1:0] slot;
        logic [PW+3:0]  v;
        o_cmd        = '0;
        o_cmd.op     = OP_NOP;
        o_cmd.ch     = i_char_byte;
        o_cmd.addr   = i_cell_address;
        o_cmd.attr   = i_attr_value;
        o_cmd.params = r_params;
        o_cmd.pcount = r_pcount;
        o_cmd.priv   = r_priv;
        n_pstate = r_pstate;
        n_params = r_params;
        n_pcount = r_pcount;
        n_hasd   = r_hasd;
        n_priv   = r_priv;
        cnt  = r_hasd ? r_pcount : r_pcount + PCW'(1);
        slot = PIW'(cnt - PCW'(1));
        v    = ({4'b0, r_params[slot]} << 3) + ({4'b0, r_params[slot]} << 1)
               + (PW+4)'(i_char_byte - CH_ZERO);
        case (t_kind'(i_kind))
            KIND_BYTE: begin
                o_cmd.op = OP_SYNC;
                case (r_pstate)
                    PS_GROUND: begin
                        if (i_char_byte == CH_ESC) n_pstate = PS_ESC;
                        else if (i_char_byte == CH_LF) o_cmd.op = OP_LF;
                        else if (i_char_byte == CH_CR) o_cmd.op = OP_CR;
                        else if (i_char_byte == CH_TAB) o_cmd.op = OP_TAB;
                        else if (i_char_byte == CH_BS) o_cmd.op = OP_BS;
                        else if (i_char_byte >= CH_SPACE) o_cmd.op = OP_PRINT;
                    end
                    PS_ESC: begin
                        n_pstate = PS_GROUND;
                        if (i_char_byte == CH_LBRACK) begin
                            n_params = '0;
                            n_pcount = '0;
                            n_hasd   = 1'b0;
                            n_priv   = 1'b0;
                            n_pstate = PS_CSI;
                        end else if (i_char_byte == CH_RIS) begin
                            o_cmd.op = OP_RIS;
                        end
                    end
                    PS_CSI: begin
                        if (i_char_byte >= CH_ZERO && i_char_byte <= CH_NINE) begin
                            // drop digits once every parameter slot is taken
                            if (r_hasd || r_pcount < PCW'(MAX_PARAMS)) begin
                                n_pcount = cnt;
                                n_hasd   = 1'b1;
                                n_params[slot] = (v > (PW+4)'(PARAM_LIMIT)) ?
                                                 PARAM_LIMIT : v[PW-1:0];
                            end
                        end else if (i_char_byte == CH_SEMI) begin
                            if (!r_hasd && r_pcount < PCW'(MAX_PARAMS))
                                n_pcount = r_pcount + PCW'(1);
                            n_hasd = 1'b0;
                        end else if (i_char_byte == CH_QUEST) begin
                            n_priv = 1'b1;
                        end else if (i_char_byte >= FIN_LO && i_char_byte <= FIN_HI) begin
                            o_cmd.op = OP_CSI;
                            n_pstate = PS_GROUND;
                        end
                    end
                    default: n_pstate = PS_GROUND;
                endcase
            end
            KIND_OPEN:  o_cmd.op = OP_OPEN;
            KIND_CLOSE: o_cmd.op = OP_CLOSE;
            KIND_READ:  o_cmd.op = OP_READ;
            KIND_ATTR:  o_cmd.op = OP_ATTR;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate <= PS_GROUND;
            r_params <= '0;
            r_pcount <= '0;
            r_hasd   <= 1'b0;
            r_priv   <= 1'b0;
        end else if (i_accept) begin
            r_pstate <= n_pstate;
            r_params <= n_params;
            r_pcount <= n_pcount;
            r_hasd   <= n_hasd;
            r_priv   <= n_priv;
        end
    end

endmodule

// ===== hdl/ate_queue.sv =====
// Short command queue between the parser and the executor.
// Depends on ate_pkg for the command type.
module ate_queue import ate_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ===== hdl/ate_back.sv =====
// Back end: executes commands on the cell store, cursor and attributes.
// Holds the cell memory and the result register. Depends on ate_pkg.
module ate_back import ate_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    output logic             o_q_pop,
    output logic             o_clearing,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OFF_W-1:0] o_cursor_offset,
    output logic [OFF_W-1:0] o_hw_cursor_offset,
    output logic             o_cursor_program,
    output logic [15:0]      o_cell_data
);

    localparam logic [OFF_W-1:0] CELL_END  = OFF_W'(CELLS);
    localparam logic [OFF_W-1:0] CELL_LAST = OFF_W'(CELLS - 1);
    localparam logic [OFF_W-1:0] LAST_ROW  = OFF_W'((ROWS - 1) * COLUMNS);
    localparam logic [OFF_W-1:0] COLS_OFF  = OFF_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX   = COL_W'(COLUMNS - 1);

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rdata;
    logic        w_we, w_re;
    logic [OFF_W-1:0] w_waddr, w_raddr;
    logic [15:0] w_wdata;

    t_bstate r_state, n_state, w_tgt;
    t_cmd    r_cmd;
    logic [7:0]       r_def;
    logic [COL_W-1:0] r_col, n_col, r_scol, n_scol;
    logic [ROW_W-1:0] r_row, n_row, r_srow, n_srow;
    logic [7:0]       r_attr, n_attr, r_sattr, n_sattr;
    logic             r_svalid, n_svalid;
    logic [OFF_W-1:0] r_hw, n_hw;
    logic             r_dirty, n_dirty;
    logic [7:0]       r_depth, n_depth;
    logic [OFF_W-1:0] r_ptr, n_ptr, r_end, n_end, r_wa, n_wa;
    logic             r_pend, n_pend;
    logic [PIW-1:0]   r_si, n_si;
    logic [3:0]       r_fg, n_fg;
    logic [2:0]       r_bg, n_bg;
    logic             r_rd_ok, n_rd_ok;
    logic             w_load, w_prog, w_sync, w_sgr_last;

    logic [OFF_W-1:0] w_off, w_lo;
    logic [15:0]      w_blank;

    assign w_off   = OFF_W'(r_row * COLUMNS) + OFF_W'(r_col);
    assign w_lo    = w_off - OFF_W'(r_col);
    assign w_blank = {r_attr, CH_SPACE};
    assign o_clearing = (r_state == BS_CLEAR);
    assign w_sync = (r_cmd.op == OP_SYNC) || (r_cmd.op == OP_PRINT) || (r_cmd.op == OP_LF)
                 || (r_cmd.op == OP_CR) || (r_cmd.op == OP_TAB) || (r_cmd.op == OP_BS)
                 || (r_cmd.op == OP_CSI) || (r_cmd.op == OP_RIS);
    assign w_sgr_last = (PCW'(r_si) + PCW'(1) == r_cmd.pcount);

    // cell memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR:  if (r_ptr == CELL_LAST) n_state = BS_IDLE;
            BS_IDLE:   if (i_q_valid) n_state = w_tgt;
            BS_FILL:   if (r_ptr == r_end) n_state = BS_FIN;
            BS_SCROLL: if (r_ptr == CELL_END) n_state = BS_FILL;
            BS_SGR:    if (w_sgr_last) n_state = BS_FIN;
            BS_FIN:    if (w_load) n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = w_blank;
        w_re    = 1'b0;
        w_raddr = r_ptr;
        o_q_pop = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = BLANK_RESET;
            end
            BS_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_PRINT: begin
                            w_we    = 1'b1;
                            w_waddr = w_off;
                            w_wdata = {r_attr, i_q_cmd.ch};
                        end
                        OP_BS: begin
                            w_we    = 1'b1;
                            w_waddr = w_off - OFF_W'(r_col != '0);
                        end
                        OP_READ: begin
                            w_re    = (i_q_cmd.addr < CELL_END);
                            w_raddr = i_q_cmd.addr;
                        end
                        default: ;
                    endcase
                end
            end
            BS_FILL: w_we = 1'b1;
            BS_SCROLL: begin
                w_re    = (r_ptr < CELL_END);
                w_we    = r_pend;
                w_waddr = r_wa;
                w_wdata = r_rdata;
            end
            BS_FIN: w_load = !o_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        logic [COL_W:0]  col_t;
        logic [ROW_W:0]  row_t;
        logic [PW-1:0]   p0, p1, pm1, nmode, p;
        logic [PW:0]     sum;
        n_col = r_col;  n_row = r_row;  n_attr = r_attr;
        n_scol = r_scol; n_srow = r_srow; n_sattr = r_sattr; n_svalid = r_svalid;
        n_hw = r_hw; n_dirty = r_dirty; n_depth = r_depth;
        n_ptr = r_ptr; n_end = r_end; n_wa = r_wa; n_pend = r_pend;
        n_si = r_si; n_fg = r_fg; n_bg = r_bg; n_rd_ok = r_rd_ok;
        w_tgt = BS_FIN;
        w_prog = 1'b0;
        col_t = {1'b0, r_col};
        row_t = {1'b0, r_row};
        p0 = (i_q_cmd.pcount != '0 && i_q_cmd.params[0] != '0) ? i_q_cmd.params[0] : PW'(1);
        p1 = (i_q_cmd.pcount > PCW'(1) && i_q_cmd.params[1] != '0) ?
             i_q_cmd.params[1] : PW'(1);
        nmode = (i_q_cmd.pcount == '0) ? '0 : i_q_cmd.params[0];
        pm1 = '0;
        sum = '0;
        p = r_cmd.params[r_si];
        case (r_state)
            BS_CLEAR: n_ptr = r_ptr + OFF_W'(1);
            BS_IDLE: if (i_q_valid) begin
                n_rd_ok = 1'b0;
                case (i_q_cmd.op)
                    OP_PRINT, OP_LF, OP_CR, OP_TAB, OP_BS: begin
                        case (i_q_cmd.op)
                            OP_PRINT: col_t = {1'b0, r_col} + (COL_W+1)'(1);
                            OP_LF: begin
                                col_t = '0;
                                row_t = {1'b0, r_row} + (ROW_W+1)'(1);
                            end
                            OP_CR:  col_t = '0;
                            OP_TAB: col_t = ({1'b0, r_col} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
                            default: col_t = (r_col != '0) ? {1'b0, r_col} - (COL_W+1)'(1)
                                                           : {1'b0, r_col};
                        endcase
                        // wrap past the last column, then scroll past the last row
                        if (col_t >= (COL_W+1)'(COLUMNS)) begin
                            col_t = '0;
                            row_t = row_t + (ROW_W+1)'(1);
                        end
                        n_col = col_t[COL_W-1:0];
                        if (row_t >= (ROW_W+1)'(ROWS)) begin
                            n_row  = ROW_MAX;
                            n_ptr  = COLS_OFF;
                            n_pend = 1'b0;
                            w_tgt  = BS_SCROLL;
                        end else begin
                            n_row = row_t[ROW_W-1:0];
                        end
                    end
                    OP_CSI: if (!i_q_cmd.priv) begin
                        case (i_q_cmd.ch)
                            FIN_CUP, FIN_HVP: begin
                                pm1   = p0 - PW'(1);
                                n_row = (pm1 > PW'(ROWS - 1)) ? ROW_MAX : pm1[ROW_W-1:0];
                                pm1   = p1 - PW'(1);
                                n_col = (pm1 > PW'(COLUMNS - 1)) ? COL_MAX : pm1[COL_W-1:0];
                            end
                            FIN_CUU: n_row = (p0 > PW'(r_row)) ? '0 : r_row - p0[ROW_W-1:0];
                            FIN_CUD: begin
                                sum   = {1'b0, p0} + (PW+1)'(r_row);
                                n_row = (sum > (PW+1)'(ROWS - 1)) ? ROW_MAX : sum[ROW_W-1:0];
                            end
                            FIN_CUF: begin
                                sum   = {1'b0, p0} + (PW+1)'(r_col);
                                n_col = (sum > (PW+1)'(COLUMNS - 1)) ? COL_MAX
                                                                     : sum[COL_W-1:0];
                            end
                            FIN_CUB: n_col = (p0 > PW'(r_col)) ? '0 : r_col - p0[COL_W-1:0];
                            FIN_ED: begin
                                if (nmode == PW'(0)) begin
                                    n_ptr = w_off; n_end = CELL_LAST; w_tgt = BS_FILL;
                                end else if (nmode == PW'(1)) begin
                                    n_ptr = '0; n_end = w_off; w_tgt = BS_FILL;
                                end else if (nmode == PW'(2) || nmode == PW'(3)) begin
                                    n_ptr = '0; n_end = CELL_LAST; w_tgt = BS_FILL;
                                    n_col = '0; n_row = '0;
                                end
                            end
                            FIN_EL: begin
                                if (nmode == PW'(0)) begin
                                    n_ptr = w_off; n_end = w_lo + COLS_OFF - OFF_W'(1);
                                    w_tgt = BS_FILL;
                                end else if (nmode == PW'(1)) begin
                                    n_ptr = w_lo; n_end = w_off; w_tgt = BS_FILL;
                                end else if (nmode == PW'(2)) begin
                                    n_ptr = w_lo; n_end = w_lo + COLS_OFF - OFF_W'(1);
                                    w_tgt = BS_FILL;
                                end
                            end
                            FIN_SGR: begin
                                if (i_q_cmd.pcount == '0) begin
                                    n_attr = r_def;
                                end else begin
                                    n_fg  = r_attr[3:0];
                                    n_bg  = r_attr[6:4];
                                    n_si  = '0;
                                    w_tgt = BS_SGR;
                                end
                            end
                            FIN_SCP: begin
                                n_scol = r_col; n_srow = r_row;
                                n_sattr = r_attr; n_svalid = 1'b1;
                            end
                            FIN_RCP: if (r_svalid) begin
                                n_col = r_scol; n_row = r_srow; n_attr = r_sattr;
                            end
                            default: ;
                        endcase
                    end
                    OP_RIS: begin
                        n_attr = r_def; n_svalid = 1'b0;
                        n_col = '0; n_row = '0;
                        n_ptr = '0; n_end = CELL_LAST; w_tgt = BS_FILL;
                    end
                    OP_OPEN:  if (r_depth != 8'hFF) n_depth = r_depth + 8'd1;
                    OP_CLOSE: if (r_depth != 8'h00) n_depth = r_depth - 8'd1;
                    OP_READ:  n_rd_ok = (i_q_cmd.addr < CELL_END);
                    OP_ATTR:  n_attr = i_q_cmd.attr;
                    default: ;
                endcase
            end
            BS_FILL: n_ptr = r_ptr + OFF_W'(1);
            BS_SCROLL: begin
                if (r_ptr < CELL_END) begin
                    n_ptr  = r_ptr + OFF_W'(1);
                    n_pend = 1'b1;
                    n_wa   = r_ptr - COLS_OFF;
                end else begin
                    n_pend = 1'b0;
                    n_ptr  = LAST_ROW;
                    n_end  = CELL_LAST;
                end
            end
            BS_SGR: begin
                if (p == PW'(0)) begin
                    n_fg = r_def[3:0]; n_bg = r_def[6:4];
                end else if (p == PW'(1)) begin
                    n_fg = r_fg | 4'h8;
                end else if (p == PW'(22)) begin
                    n_fg = r_fg & 4'h7;
                end else if (p >= PW'(30) && p <= PW'(37)) begin
                    pm1 = p - PW'(30); n_fg = {r_fg[3], pm1[2:0]};
                end else if (p >= PW'(40) && p <= PW'(47)) begin
                    pm1 = p - PW'(40); n_bg = pm1[2:0];
                end else if (p >= PW'(90) && p <= PW'(97)) begin
                    pm1 = p - PW'(90); n_fg = {1'b1, pm1[2:0]};
                end else if (p >= PW'(100) && p <= PW'(107)) begin
                    pm1 = p - PW'(100); n_bg = pm1[2:0];
                end
                n_si = r_si + PIW'(1);
                if (w_sgr_last) n_attr = {1'b0, n_bg, n_fg};
            end
            BS_FIN: begin
                if (w_sync) begin
                    if (w_off == r_hw) n_dirty = 1'b0;
                    else if (r_depth != 8'h00) n_dirty = 1'b1;
                    else begin
                        n_hw = w_off; n_dirty = 1'b0; w_prog = 1'b1;
                    end
                end else if (r_cmd.op == OP_CLOSE && r_depth == 8'h00 && r_dirty) begin
                    n_hw = w_off; n_dirty = 1'b0; w_prog = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_CLEAR;
            r_ptr    <= '0;
            r_def    <= ATTR_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_attr   <= ATTR_RESET;
            r_scol   <= '0;
            r_srow   <= '0;
            r_sattr  <= ATTR_RESET;
            r_svalid <= 1'b0;
            r_hw     <= '0;
            r_dirty  <= 1'b0;
            r_depth  <= '0;
            r_pend   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_def <= i_cfg_data;
            r_col  <= n_col;   r_row  <= n_row;   r_attr  <= n_attr;
            r_scol <= n_scol;  r_srow <= n_srow;  r_sattr <= n_sattr;
            r_svalid <= n_svalid;
            r_depth  <= n_depth;
            r_ptr  <= n_ptr;
            r_pend <= n_pend;
            if (w_load) begin
                r_hw    <= n_hw;
                r_dirty <= n_dirty;
            end
            if (w_load) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_wa    <= n_wa;
        r_si    <= n_si;
        r_fg    <= n_fg;
        r_bg    <= n_bg;
        r_rd_ok <= n_rd_ok;
        if (o_q_pop) r_cmd <= i_q_cmd;
        if (w_load) begin
            o_cursor_offset    <= w_off;
            o_hw_cursor_offset <= n_hw;
            o_cursor_program   <= w_prog;
            o_cell_data        <= (r_cmd.op == OP_READ && r_rd_ok) ? r_rdata : 16'h0000;
        end
    end

endmodule

// ===== hdl/ansi_text_console_engine.sv =====
// ANSI text console engine, top level.
// Depends on ate_pkg, ate_front, ate_queue and ate_back.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transaction carries a kind
//    (console byte, batch open, batch close, read cell, set attribute) and its
//    payload fields. Every transaction yields exactly one result transaction.
//  - Output channel (o_out_valid / i_out_stall): logical cursor offset, the
//    offset last programmed into the display cursor, a program strobe and the
//    cell read back for read transactions (zero otherwise).
//  - Config channel (i_cfg_valid / o_cfg_ready): writes the default attribute.
//    Ready is always high; write only while the block is idle.
//  - Throughput: an ordinary item passes the executor through a dispatch step
//    and a result step, which waits while the receiver stalls. Erases clear one
//    cell per cycle; scroll reads each moved cell and writes it back one row up,
//    one per cycle, then blanks the bottom row; SGR takes one parameter per
//    cycle.
//  - Result path: with the queue empty, an accepted transaction is queued,
//    popped by the executor and its result registered onto o_out_valid.
//  - Reset: a clearing pass writes the blank cell to all COLUMNS * ROWS
//    entries, one per cycle; o_in_stall stays high meanwhile.
//  - Receiver stall: the result register holds; the command queue keeps
//    taking transactions until it fills, then o_in_stall rises.
module ansi_text_console_engine import ate_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_kind,
    input  logic [7:0]       i_char_byte,
    input  logic [OFF_W-1:0] i_cell_address,
    input  logic [7:0]       i_attr_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OFF_W-1:0] o_cursor_offset,
    output logic [OFF_W-1:0] o_hw_cursor_offset,
    output logic             o_cursor_program,
    output logic [15:0]      o_cell_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data
);

    logic w_accept, w_full, w_clearing, w_q_valid, w_pop;
    t_cmd w_cmd, w_q_cmd;

    // hold off input while the queue is full or the store is being cleared
    assign o_in_stall  = w_full || w_clearing;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    ate_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_kind         (i_kind),
        .i_char_byte    (i_char_byte),
        .i_cell_address (i_cell_address),
        .i_attr_value   (i_attr_value),
        .o_cmd          (w_cmd)
    );

    ate_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd)
    );

    ate_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_q_valid          (w_q_valid),
        .i_q_cmd            (w_q_cmd),
        .o_q_pop            (w_pop),
        .o_clearing         (w_clearing),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_cursor_offset    (o_cursor_offset),
        .o_hw_cursor_offset (o_hw_cursor_offset),
        .o_cursor_program   (o_cursor_program),
        .o_cell_data        (o_cell_data)
    );

endmodule

// ===== hdl/ate_checker.sv =====
// Port-level checks for the ANSI text console engine, bound to the top level.
// Depends on ate_pkg and ansi_text_console_engine.
module ate_checker import ate_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [OFF_W-1:0] o_cursor_offset,
    input logic [OFF_W-1:0] o_hw_cursor_offset,
    input logic             o_cursor_program,
    input logic [15:0]      o_cell_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_offset)
            && $stable(o_hw_cursor_offset) && $stable(o_cell_data))
        else $error("result changed while stalled");

    a_program_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cursor_program |-> o_hw_cursor_offset == o_cursor_offset)
        else $error("programmed cursor differs from logical cursor");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_offset < OFF_W'(CELLS)
            && o_hw_cursor_offset < OFF_W'(CELLS))
        else $error("cursor offset outside the screen");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("activity right after reset");

endmodule

bind ansi_text_console_engine ate_checker u_ate_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for ansi_text_console_engine: a directed table, then
// random console traffic checked against a cycle-free predictor kept here.
// Depends on ate_pkg and the RTL of the engine only.
module tb;
    import ate_pkg::*;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int HOLD_CYCLES  = 400;

    // Clock and the ports of the engine.
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [2:0]       i_kind = '0;
    logic [7:0]       i_char_byte = '0;
    logic [OFF_W-1:0] i_cell_address = '0;
    logic [7:0]       i_attr_value = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b1;
    logic [OFF_W-1:0] o_cursor_offset;
    logic [OFF_W-1:0] o_hw_cursor_offset;
    logic             o_cursor_program;
    logic [15:0]      o_cell_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ansi_text_console_engine i_dut (.*);

    // One result transaction as seen on the output port.
    typedef struct packed {
        logic [OFF_W-1:0] cursor;
        logic [OFF_W-1:0] hw;
        logic             prog;
        logic [15:0]      data;
    } t_view;

    // Per-transaction note from the sender: use a typed expectation or not.
    typedef struct packed {
        logic  typed;
        t_view want;
    } t_note;

    t_view view_q[$];     // expected results, oldest first
    t_note note_q[$];     // notes for transactions on the input channel

    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned scrolls_seen = 0;
    int unsigned programs_seen = 0;
    bit          zero_idle = 1'b0;   // no gaps on either side
    bit          long_hold = 1'b0;   // receiver holds off for a long stretch
    bit          hold_done = 1'b0;   // the long hold has been requested

    // ---------------------------------------------------------------
    // Console predictor: screen image, cursor, parser and batching.
    // ---------------------------------------------------------------
    logic [15:0]   scr [CELLS];
    logic [7:0]    dflt_attr, cur_attr, sv_attr;
    int unsigned   col, row, sv_col, sv_row;
    bit            sv_ok;
    t_pstate       pstate;
    int unsigned   pval [MAX_PARAMS];
    int unsigned   pcnt;
    bit            pdig, priv_seq;
    int unsigned   hw_off;
    bit            dirty, prog_now;
    int unsigned   depth;

    function automatic int unsigned cur_cell();
        return row * COLUMNS + col;
    endfunction

    function automatic void wipe(int unsigned lo, int unsigned hi);
        if (hi >= CELLS) hi = CELLS - 1;
        for (int unsigned i = lo; i <= hi; i++) scr[i] = {cur_attr, CH_SPACE};
    endfunction

    function automatic void program_hw(int unsigned off);
        hw_off = off;
        dirty = 1'b0;
        prog_now = 1'b1;
    endfunction

    function automatic void sync_hw();
        if (cur_cell() == hw_off) dirty = 1'b0;
        else if (depth != 0) dirty = 1'b1;
        else program_hw(cur_cell());
    endfunction

    function automatic int unsigned par(int unsigned idx, int unsigned fb);
        if (idx >= pcnt || pval[idx] == 0) return fb;
        return pval[idx];
    endfunction

    function automatic int unsigned up_to(int unsigned v, int unsigned n, int unsigned top);
        return (v + n > top) ? top : v + n;
    endfunction

    function automatic int unsigned down_by(int unsigned v, int unsigned n);
        return (n > v) ? 0 : v - n;
    endfunction

    function automatic void model_reset();
        dflt_attr = ATTR_RESET;
        cur_attr = ATTR_RESET;
        sv_attr = ATTR_RESET;
        foreach (scr[i]) scr[i] = BLANK_RESET;
        col = 0; row = 0; sv_col = 0; sv_row = 0; sv_ok = 1'b0;
        pstate = PS_GROUND;
        foreach (pval[i]) pval[i] = 0;
        pcnt = 0; pdig = 1'b0; priv_seq = 1'b0;
        hw_off = 0; dirty = 1'b0; depth = 0;
    endfunction

    function automatic void apply_sgr();
        logic [3:0] fg;
        logic [2:0] bg;
        int unsigned p;
        fg = cur_attr[3:0];
        bg = cur_attr[6:4];
        if (pcnt == 0) begin
            cur_attr = dflt_attr;
            return;
        end
        for (int unsigned i = 0; i < pcnt; i++) begin
            p = pval[i];
            if (p == 0) begin
                fg = dflt_attr[3:0];
                bg = dflt_attr[6:4];
            end else if (p == 1) fg[3] = 1'b1;
            else if (p == 22) fg[3] = 1'b0;
            else if (p >= 30 && p <= 37) fg[2:0] = 3'(p - 30);
            else if (p >= 40 && p <= 47) bg = 3'(p - 40);
            else if (p >= 90 && p <= 97) fg = {1'b1, 3'(p - 90)};
            else if (p >= 100 && p <= 107) bg = 3'(p - 100);
        end
        cur_attr = {1'b0, bg, fg};
    endfunction

    function automatic void run_final(logic [7:0] fin);
        int unsigned n, lo;
        if (priv_seq) return;
        n = (pcnt == 0) ? 0 : pval[0];
        lo = row * COLUMNS;
        case (fin)
            FIN_CUP, FIN_HVP: begin
                row = up_to(0, par(0, 1) - 1, ROWS - 1);
                col = up_to(0, par(1, 1) - 1, COLUMNS - 1);
            end
            FIN_CUU: row = down_by(row, par(0, 1));
            FIN_CUD: row = up_to(row, par(0, 1), ROWS - 1);
            FIN_CUF: col = up_to(col, par(0, 1), COLUMNS - 1);
            FIN_CUB: col = down_by(col, par(0, 1));
            FIN_ED: begin
                if (n == 0) wipe(cur_cell(), CELLS - 1);
                else if (n == 1) wipe(0, cur_cell());
                else if (n == 2 || n == 3) begin
                    wipe(0, CELLS - 1);
                    col = 0;
                    row = 0;
                end
            end
            FIN_EL: begin
                if (n == 0) wipe(lo + col, lo + COLUMNS - 1);
                else if (n == 1) wipe(lo, lo + col);
                else if (n == 2) wipe(lo, lo + COLUMNS - 1);
            end
            FIN_SGR: apply_sgr();
            FIN_SCP: begin
                sv_col = col; sv_row = row; sv_attr = cur_attr; sv_ok = 1'b1;
            end
            FIN_RCP: if (sv_ok) begin
                col = sv_col; row = sv_row; cur_attr = sv_attr;
            end
            default: ;
        endcase
    endfunction

    function automatic void plain_byte(logic [7:0] ch);
        if (ch == CH_ESC) begin
            pstate = PS_ESC;
            return;
        end
        if (ch == CH_LF) begin
            col = 0;
            row++;
        end else if (ch == CH_CR) col = 0;
        else if (ch == CH_TAB) col = (col + 8) & ~7;
        else if (ch == CH_BS) begin
            if (col > 0) col--;
            scr[cur_cell()] = {cur_attr, CH_SPACE};
        end else if (ch >= CH_SPACE) begin
            scr[cur_cell()] = {cur_attr, ch};
            col++;
        end
        if (col >= COLUMNS) begin
            col = 0;
            row++;
        end
        if (row >= ROWS) begin
            // Shift up one row and blank the bottom one.
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) scr[i] = scr[i + COLUMNS];
            wipe((ROWS - 1) * COLUMNS, CELLS - 1);
            row = ROWS - 1;
            scrolls_seen++;
        end
    endfunction

    function automatic void seq_byte(logic [7:0] ch);
        int unsigned v;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (!pdig) begin
                if (pcnt >= MAX_PARAMS) return;
                pcnt++;
                pdig = 1'b1;
            end
            v = pval[pcnt - 1] * 10 + (ch - CH_ZERO);
            pval[pcnt - 1] = (v > PARAM_LIMIT) ? PARAM_LIMIT : v;
        end else if (ch == CH_SEMI) begin
            if (!pdig && pcnt < MAX_PARAMS) pcnt++;
            pdig = 1'b0;
        end else if (ch == CH_QUEST) priv_seq = 1'b1;
        else if (ch >= FIN_LO && ch <= FIN_HI) begin
            run_final(ch);
            pstate = PS_GROUND;
        end
    endfunction

    function automatic void feed_byte(logic [7:0] ch);
        case (pstate)
            PS_ESC: begin
                pstate = PS_GROUND;
                if (ch == CH_LBRACK) begin
                    foreach (pval[i]) pval[i] = 0;
                    pcnt = 0; pdig = 1'b0; priv_seq = 1'b0;
                    pstate = PS_CSI;
                end else if (ch == CH_RIS) begin
                    cur_attr = dflt_attr;
                    sv_ok = 1'b0;
                    wipe(0, CELLS - 1);
                    col = 0;
                    row = 0;
                    sync_hw();
                end
            end
            PS_CSI: seq_byte(ch);
            default: plain_byte(ch);
        endcase
    endfunction

    // Advance the console by one transaction and return what it reports.
    function automatic t_view console_step(logic [2:0] kind, logic [7:0] ch,
                                           logic [OFF_W-1:0] addr, logic [7:0] attr);
        t_view r;
        r.data = '0;
        prog_now = 1'b0;
        case (kind)
            KIND_BYTE: begin
                feed_byte(ch);
                sync_hw();
            end
            KIND_OPEN: if (depth < 255) depth++;
            KIND_CLOSE: begin
                if (depth > 0) depth--;
                if (depth == 0 && dirty) program_hw(cur_cell());
            end
            KIND_READ: if (addr < CELLS) r.data = scr[addr];
            KIND_ATTR: cur_attr = attr;
            default: ;
        endcase
        r.cursor = OFF_W'(cur_cell());
        r.hw = OFF_W'(hw_off);
        r.prog = prog_now;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Monitors: sample at the falling edge, when every port is settled
    // and a transaction at the next rising edge is already decided.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_view model;
        t_note note;
        t_view want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            // Step the predictor always; a typed row overrides its answer.
            model = console_step(i_kind, i_char_byte, i_cell_address, i_attr_value);
            note = note_q.pop_front();
            view_q.push_back(note.typed ? note.want : model);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_cursor_program) programs_seen++;
            if (view_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction, cursor %0d", o_cursor_offset);
            end else begin
                want = view_q.pop_front();
                if (want.cursor !== o_cursor_offset || want.hw !== o_hw_cursor_offset ||
                    want.prog !== o_cursor_program || want.data !== o_cell_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: exp cur %0d hw %0d prog %0b cell %h, got cur %0d hw %0d prog %0b cell %h",
                                 results_seen, want.cursor, want.hw, want.prog, want.data,
                                 o_cursor_offset, o_hw_cursor_offset, o_cursor_program,
                                 o_cell_data);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver: random stall before each result, one long hold on request.
    initial begin
        int unsigned n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            n = zero_idle ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(negedge i_clk); while (!o_out_valid);
            @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Sender side.
    // ---------------------------------------------------------------
    task automatic offer(logic [2:0] kind, logic [7:0] ch, logic [OFF_W-1:0] addr,
                         logic [7:0] attr, bit typed = 1'b0, t_view want = '0);
        int unsigned gap;
        gap = zero_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        note_q.push_back({typed, want});
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_char_byte <= ch;
        i_cell_address <= addr;
        i_attr_value <= attr;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic put_byte(logic [7:0] ch);
        offer(KIND_BYTE, ch, OFF_W'($urandom), 8'($urandom));
    endtask

    // Hold the sender until every expected result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (view_q.size() != 0 || note_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the default attribute while idle; the tail covers a scroll or erase.
    task automatic set_default(logic [7:0] value);
        drain();
        repeat (30) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        dflt_attr = value;
    endtask

    function automatic int unsigned pick_param();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return $urandom_range(1, 3);
            2: return 22;
            3: return $urandom_range(30, 37);
            4: return $urandom_range(40, 47);
            5: return $urandom_range(90, 97);
            6: return $urandom_range(100, 107);
            7: return $urandom_range(0, 99999);
            default: return $urandom_range(0, 30);
        endcase
    endfunction

    task automatic put_number(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // A control sequence with random parameters and a weighted final.
    task automatic put_csi();
        logic [7:0] finals [14] = '{FIN_CUP, FIN_HVP, FIN_CUU, FIN_CUD, FIN_CUF, FIN_CUB,
                                    FIN_ED, FIN_EL, FIN_SGR, FIN_SGR, FIN_SCP, FIN_RCP,
                                    8'h5A, FIN_HI};
        logic [7:0]  fin;
        int unsigned np;
        put_byte(CH_ESC);
        put_byte(CH_LBRACK);
        if ($urandom_range(0, 9) == 0) put_byte(CH_QUEST);
        fin = finals[$urandom_range(0, 13)];
        // Keep full-screen erases rare; they clear every cell of the store.
        np = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : $urandom_range(0, 2);
        for (int unsigned i = 0; i < np; i++) begin
            if (i > 0) put_byte(CH_SEMI);
            if (fin == FIN_ED && i == 0) put_number($urandom_range(0, 7) == 0 ? 2 : 0);
            else if ($urandom_range(0, 7) != 0) put_number(pick_param());
            if ($urandom_range(0, 15) == 0)
                put_byte($urandom_range(0, 1) ? CH_ESC : 8'($urandom_range(0, 8'h2F)));
        end
        put_byte(fin);
    endtask

    task automatic random_burst();
        int unsigned r, n;
        r = $urandom_range(0, 99);
        if (r < 38) begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(8'($urandom_range(8'h20, 8'hFF)));
        end else if (r < 60) put_csi();
        else if (r < 67) begin
            n = $urandom_range(0, 19);
            if (n < 4) put_byte(CH_BS);
            else if (n < 8) put_byte(CH_TAB);
            else if (n < 11) put_byte(CH_CR);
            else if (n < 12) put_byte(CH_LF);
            else put_byte(8'($urandom_range(0, 8'h1F)));
        end else if (r < 72) begin
            put_byte(CH_ESC);
            if ($urandom_range(0, 3) == 0) put_byte(CH_RIS);
            else put_byte(8'($urandom));
        end else if (r < 82) begin
            offer(KIND_READ, 8'($urandom),
                  $urandom_range(0, 15) == 0 ? OFF_W'($urandom) : OFF_W'($urandom_range(0, CELLS - 1)),
                  8'($urandom));
        end else if (r < 86) offer(KIND_ATTR, 8'($urandom), OFF_W'($urandom), 8'($urandom));
        else if (r < 95) begin
            offer(KIND_OPEN, 8'($urandom), OFF_W'($urandom), 8'($urandom));
            n = $urandom_range(0, 3);
            repeat (n) random_burst();
            offer(KIND_CLOSE, 8'($urandom), OFF_W'($urandom), 8'($urandom));
        end else if (r < 97) offer(3'($urandom_range(5, 7)), 8'($urandom), OFF_W'($urandom), 8'($urandom));
        else put_byte(8'($urandom));
    endtask

    // Directed rows: kind, byte, address, attribute, typed flag, expectation.
    typedef struct {
        logic [2:0]       kind;
        logic [7:0]       ch;
        logic [OFF_W-1:0] addr;
        logic [7:0]       attr;
        bit               typed;
        t_view            want;
    } t_row;

    t_row rows [] = '{
        '{KIND_READ,  0,       0,    0,     1, '{0, 0, 0, 16'h0720}},
        '{KIND_READ,  0,       1999, 0,     1, '{0, 0, 0, 16'h0720}},
        '{KIND_READ,  0,       2047, 0,     1, '{0, 0, 0, 16'h0000}},
        '{3'd7,       0,       0,    0,     1, '{0, 0, 0, 16'h0000}},
        '{KIND_BYTE,  8'h41,   0,    0,     1, '{1, 1, 1, 16'h0000}},
        '{KIND_READ,  0,       0,    0,     1, '{1, 1, 0, 16'h0741}},
        '{KIND_OPEN,  0,       0,    0,     1, '{1, 1, 0, 16'h0000}},
        '{KIND_BYTE,  8'hFF,   0,    0,     1, '{2, 1, 0, 16'h0000}},
        '{KIND_CLOSE, 0,       0,    0,     1, '{2, 2, 1, 16'h0000}},
        '{KIND_CLOSE, 0,       0,    0,     1, '{2, 2, 0, 16'h0000}},
        '{KIND_ATTR,  0,       0,    8'hFF, 1, '{2, 2, 0, 16'h0000}},
        '{KIND_BYTE,  CH_ESC,  0,    0,     0, '0},
        '{KIND_BYTE,  CH_LBRACK, 0,  0,     0, '0},
        '{KIND_BYTE,  "2",     0,    0,     0, '0},
        '{KIND_BYTE,  FIN_ED,  0,    0,     1, '{0, 0, 1, 16'h0000}},
        '{KIND_READ,  0,       5,    0,     1, '{0, 0, 0, 16'hFF20}},
        '{KIND_BYTE,  CH_ESC,  0,    0,     0, '0},
        '{KIND_BYTE,  CH_LBRACK, 0,  0,     0, '0},
        '{KIND_BYTE,  CH_QUEST, 0,   0,     0, '0},
        '{KIND_BYTE,  "5",     0,    0,     0, '0},
        '{KIND_BYTE,  FIN_CUP, 0,    0,     1, '{0, 0, 0, 16'h0000}},
        '{KIND_BYTE,  CH_TAB,  0,    0,     1, '{8, 8, 1, 16'h0000}},
        '{KIND_BYTE,  CH_BS,   0,    0,     1, '{7, 7, 1, 16'h0000}},
        '{KIND_BYTE,  CH_CR,   0,    0,     1, '{0, 0, 1, 16'h0000}},
        '{KIND_BYTE,  8'h01,   0,    0,     1, '{0, 0, 0, 16'h0000}}
    };

    initial begin
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table at the reset default attribute.
        foreach (rows[i])
            offer(rows[i].kind, rows[i].ch, rows[i].addr, rows[i].attr,
                  rows[i].typed, rows[i].want);
        // Clamped and surplus parameters, then a terminal reset.
        put_byte(CH_ESC); put_byte(CH_LBRACK);
        put_number(123456); put_byte(CH_SEMI); put_number(99999); put_byte(FIN_CUP);
        put_byte(CH_ESC); put_byte(CH_LBRACK);
        repeat (10) begin put_number(31); put_byte(CH_SEMI); end
        put_byte(FIN_SGR);
        put_byte(CH_ESC); put_byte(CH_LBRACK); put_byte(FIN_RCP);
        put_byte(CH_ESC); put_byte(CH_RIS);

        // Random phases under different default attributes.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_default(8'h00);
                1: set_default(8'hFF);
                2: set_default(8'($urandom));
                default: set_default(ATTR_RESET);
            endcase
            zero_idle = (phase == 2);
            if (phase == 1) begin
                // Saturate the batch depth and unwind it past zero.
                repeat (258) offer(KIND_OPEN, 8'($urandom), 0, 0);
                repeat (4) put_byte(8'($urandom_range(8'h20, 8'h7E)));
                repeat (260) offer(KIND_CLOSE, 8'($urandom), 0, 0);
            end
            while (items_sent < 225 * (phase + 1) + 500 * (phase >= 1)) begin
                if (phase == 0 && items_sent >= 150 && !hold_done) begin
                    long_hold = 1'b1;
                    hold_done = 1'b1;
                end
                if (phase == 3 && items_sent % 150 == 0) drain();
                random_burst();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("tb: %0d transactions, %0d results, %0d scrolls, %0d cursor programs, %0d mismatches",
                 items_sent, results_seen, scrolls_seen, programs_seen, mismatches);
        $display("tb: four default attribute settings, batching, CSI finals, reads past the store");
        if (mismatches == 0 && view_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
